>>> hw/rtl/giou_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package giou_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
endpackage
`default_nettype wire

>>> hw/rtl/generalized_box_iou_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Generalized IoU of one box pair per transfer.
// From the edge that accepts the input, a pair passes registers for spans,
// products, FRAC_BITS division cells and the GIoU output. Throughput: one
// pair per cycle while out_ready does not stall the output, set by the chain
// of division cells. Synchronous active-low reset empties the pipeline.
module generalized_box_iou_unit #(
  parameter int COORD_BITS = giou_pkg::COORD_BITS,
  parameter int FRAC_BITS  = giou_pkg::FRAC_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   in_a_left,
  input  wire logic [COORD_BITS-1:0]   in_a_top,
  input  wire logic [COORD_BITS-1:0]   in_a_right,
  input  wire logic [COORD_BITS-1:0]   in_a_bottom,
  input  wire logic [COORD_BITS-1:0]   in_b_left,
  input  wire logic [COORD_BITS-1:0]   in_b_top,
  input  wire logic [COORD_BITS-1:0]   in_b_right,
  input  wire logic [COORD_BITS-1:0]   in_b_bottom,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [FRAC_BITS:0]           out_iou_value,
  output logic signed [FRAC_BITS+1:0]  out_giou_value,
  output logic [2*COORD_BITS:0]        out_union_area,
  output logic                         out_bad_box
);
  localparam int AB = 2 * COORD_BITS + 1;
  localparam int QB = FRAC_BITS + 1;
  localparam int NC = FRAC_BITS;
  localparam int PB = 2 * COORD_BITS;

  // The whole pipeline advances together whenever the output stage is free
  // or being drained, so a stall holds every stage in place.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: spans and the inverted-box check.
  logic                  s1_vld_r, s1_bad_r;
  logic [COORD_BITS-1:0] s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;
  logic [COORD_BITS-1:0] s1_iw_r, s1_ih_r, s1_ew_r, s1_eh_r;
  logic [COORD_BITS-1:0] ix0, ix1, iy0, iy1, ex0, ex1, ey0, ey1;

  always_comb begin
    ix0 = (in_a_left > in_b_left) ? in_a_left : in_b_left;
    ix1 = (in_a_right < in_b_right) ? in_a_right : in_b_right;
    iy0 = (in_a_top > in_b_top) ? in_a_top : in_b_top;
    iy1 = (in_a_bottom < in_b_bottom) ? in_a_bottom : in_b_bottom;
    ex0 = (in_a_left < in_b_left) ? in_a_left : in_b_left;
    ex1 = (in_a_right > in_b_right) ? in_a_right : in_b_right;
    ey0 = (in_a_top < in_b_top) ? in_a_top : in_b_top;
    ey1 = (in_a_bottom > in_b_bottom) ? in_a_bottom : in_b_bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
    if (en) begin
      s1_bad_r <= (in_a_right < in_a_left) || (in_a_bottom < in_a_top) ||
                  (in_b_right < in_b_left) || (in_b_bottom < in_b_top);
      s1_aw_r <= in_a_right - in_a_left;
      s1_ah_r <= in_a_bottom - in_a_top;
      s1_bw_r <= in_b_right - in_b_left;
      s1_bh_r <= in_b_bottom - in_b_top;
      s1_iw_r <= (ix1 > ix0) ? ix1 - ix0 : '0;
      s1_ih_r <= (iy1 > iy0) ? iy1 - iy0 : '0;
      s1_ew_r <= ex1 - ex0;
      s1_eh_r <= ey1 - ey0;
    end
  end

  // Stage 2: the four products, each registered.
  logic          s2_vld_r, s2_bad_r;
  logic [PB-1:0] s2_aa_r, s2_ba_r, s2_in_r, s2_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_bad_r <= s1_bad_r;
      s2_aa_r  <= PB'(s1_aw_r) * PB'(s1_ah_r);
      s2_ba_r  <= PB'(s1_bw_r) * PB'(s1_bh_r);
      s2_in_r  <= PB'(s1_iw_r) * PB'(s1_ih_r);
      s2_en_r  <= PB'(s1_ew_r) * PB'(s1_eh_r);
    end
  end

  // Union, clamped divisors and the integer quotient bit feed the first cell.
  // The intersection never exceeds the union and the union never exceeds
  // the enclosing box, so the leading quotient bit is a single compare.
  logic [AB-1:0] uni, iden, pden, pnum;
  logic          iq0, pq0;
  logic [AB:0]   irem0, prem0;

  always_comb begin
    uni  = AB'({1'b0, s2_aa_r} + {1'b0, s2_ba_r} - {1'b0, s2_in_r});
    iden = (uni == '0) ? AB'(1) : uni;
    pden = (s2_en_r == '0) ? AB'(1) : {1'b0, s2_en_r};
    pnum = ({1'b0, s2_en_r} >= uni) ? AB'({1'b0, s2_en_r} - uni) : '0;
    iq0  = {1'b0, s2_in_r} >= iden;
    pq0  = pnum >= pden;
    irem0 = {1'b0, iq0 ? AB'({1'b0, s2_in_r} - iden) : {1'b0, s2_in_r}};
    prem0 = {1'b0, pq0 ? AB'(pnum - pden) : pnum};
  end

  logic          c_vld [NC+1];
  logic          c_bad [NC+1];
  logic [AB-1:0] c_iden [NC+1];
  logic [AB-1:0] c_pden [NC+1];
  logic [AB:0]   c_irem [NC+1];
  logic [AB:0]   c_prem [NC+1];
  logic [QB-1:0] c_iq [NC+1];
  logic [QB-1:0] c_pq [NC+1];
  logic [AB-1:0] c_uni [NC+1];

  assign c_vld[0]  = s2_vld_r;
  assign c_bad[0]  = s2_bad_r;
  assign c_iden[0] = iden;
  assign c_pden[0] = pden;
  assign c_irem[0] = irem0;
  assign c_prem[0] = prem0;
  assign c_iq[0]   = {{(QB-1){1'b0}}, iq0};
  assign c_pq[0]   = {{(QB-1){1'b0}}, pq0};
  assign c_uni[0]  = uni;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    giou_div_cell #(.AREA_BITS(AB), .Q_BITS(QB)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (c_vld[g]),
      .iden_i (c_iden[g]),
      .irem_i (c_irem[g]),
      .iq_i   (c_iq[g]),
      .pden_i (c_pden[g]),
      .prem_i (c_prem[g]),
      .pq_i   (c_pq[g]),
      .uni_i  (c_uni[g]),
      .bad_i  (c_bad[g]),
      .vld_o  (c_vld[g+1]),
      .iden_o (c_iden[g+1]),
      .irem_o (c_irem[g+1]),
      .iq_o   (c_iq[g+1]),
      .pden_o (c_pden[g+1]),
      .prem_o (c_prem[g+1]),
      .pq_o   (c_pq[g+1]),
      .uni_o  (c_uni[g+1]),
      .bad_o  (c_bad[g+1])
    );
  end

  // Output register: GIoU is the difference of the two truncated quotients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld[NC];
    end
    if (en) begin
      out_bad_box <= c_bad[NC];
      if (c_bad[NC]) begin
        out_iou_value  <= '0;
        out_giou_value <= '0;
        out_union_area <= '0;
      end else begin
        out_iou_value  <= c_iq[NC];
        out_giou_value <= $signed({1'b0, c_iq[NC]} - {1'b0, c_pq[NC]});
        out_union_area <= c_uni[NC];
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/giou_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring-division step for two independent quotients. Each cell
// takes the partial remainders from its left neighbor, resolves one
// quotient bit of each division and hands everything to the right.
module giou_div_cell #(
  parameter int AREA_BITS = 33,
  parameter int Q_BITS    = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire logic [AREA_BITS-1:0] iden_i,
  input  wire logic [AREA_BITS:0]   irem_i,
  input  wire logic [Q_BITS-1:0]    iq_i,
  input  wire logic [AREA_BITS-1:0] pden_i,
  input  wire logic [AREA_BITS:0]   prem_i,
  input  wire logic [Q_BITS-1:0]    pq_i,
  input  wire logic [AREA_BITS-1:0] uni_i,
  input  wire logic                 bad_i,
  output logic                      vld_o,
  output logic [AREA_BITS-1:0]      iden_o,
  output logic [AREA_BITS:0]        irem_o,
  output logic [Q_BITS-1:0]         iq_o,
  output logic [AREA_BITS-1:0]      pden_o,
  output logic [AREA_BITS:0]        prem_o,
  output logic [Q_BITS-1:0]         pq_o,
  output logic [AREA_BITS-1:0]      uni_o,
  output logic                      bad_o
);
  logic [AREA_BITS+1:0] ish, psh;
  logic                 ige, pge;
  logic [AREA_BITS:0]   irem_nxt, prem_nxt;

  always_comb begin
    ish = {irem_i, 1'b0};
    psh = {prem_i, 1'b0};
    ige = ish >= {2'b00, iden_i};
    pge = psh >= {2'b00, pden_i};
    irem_nxt = ige ? (AREA_BITS+1)'(ish - {2'b00, iden_i}) : ish[AREA_BITS:0];
    prem_nxt = pge ? (AREA_BITS+1)'(psh - {2'b00, pden_i}) : psh[AREA_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      iden_o <= iden_i;
      pden_o <= pden_i;
      irem_o <= irem_nxt;
      prem_o <= prem_nxt;
      iq_o   <= {iq_i[Q_BITS-2:0], ige};
      pq_o   <= {pq_i[Q_BITS-2:0], pge};
      uni_o  <= uni_i;
      bad_o  <= bad_i;
    end
  end
endmodule
`default_nettype wire
